@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/shapow_pkg.sv @@
package shapow_pkg;

  localparam int unsigned NumRounds = 64;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hstate_t;
  typedef word_t [15:0] sched_t;

  // Payload that travels beside the hash state.
  typedef struct packed {
    logic [63:0] nonce;
    logic [63:0] key;
  } tag_t;

  localparam hstate_t InitH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

  // Fixed text, message words 0 to 11, big-endian.
  localparam logic [31:0] TextW [12] = '{
    32'h456d6265, 32'h64646564, 32'h20537973, 32'h74656d73,
    32'h20617265, 32'h2066756e, 32'h20616e64, 32'h20646f20,
    32'h61776573, 32'h6f6d6520, 32'h7468696e, 32'h67732120};

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

@@ hw/rtl/shapow_round.sv @@
// One SHA-256 round plus one message schedule step, registered.
module shapow_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic [5:0]           rnd,
  input  logic                 vld_i,
  input  shapow_pkg::hstate_t  st_i,
  input  shapow_pkg::sched_t   w_i,
  input  shapow_pkg::hstate_t  base_i,
  input  shapow_pkg::tag_t     tag_i,
  output logic                 vld_o,
  output shapow_pkg::hstate_t  st_o,
  output shapow_pkg::sched_t   w_o,
  output shapow_pkg::hstate_t  base_o,
  output shapow_pkg::tag_t     tag_o
);

  shapow_pkg::word_t s1, ch, s0, maj, t1, t2, ws0, ws1, wn;
  shapow_pkg::hstate_t st_nxt;
  shapow_pkg::sched_t  w_nxt;
  logic                vld_r;
  shapow_pkg::hstate_t st_r, base_r;
  shapow_pkg::sched_t  w_r;
  shapow_pkg::tag_t    tag_r;

  // st[0]=a ... st[7]=h; w[0] is the word used this round.
  always_comb begin
    s1  = shapow_pkg::rotr(st_i[4], 6) ^ shapow_pkg::rotr(st_i[4], 11) ^
          shapow_pkg::rotr(st_i[4], 25);
    ch  = (st_i[4] & st_i[5]) ^ (~st_i[4] & st_i[6]);
    s0  = shapow_pkg::rotr(st_i[0], 2) ^ shapow_pkg::rotr(st_i[0], 13) ^
          shapow_pkg::rotr(st_i[0], 22);
    maj = (st_i[0] & st_i[1]) ^ (st_i[0] & st_i[2]) ^ (st_i[1] & st_i[2]);
    t1  = st_i[7] + s1 + ch + shapow_pkg::round_k(rnd) + w_i[0];
    t2  = s0 + maj;
    st_nxt = {st_i[6:4], st_i[3] + t1, st_i[2:0], t1 + t2};
    ws0 = shapow_pkg::rotr(w_i[1], 7) ^ shapow_pkg::rotr(w_i[1], 18) ^ (w_i[1] >> 3);
    ws1 = shapow_pkg::rotr(w_i[14], 17) ^ shapow_pkg::rotr(w_i[14], 19) ^
          (w_i[14] >> 10);
    wn  = w_i[0] + ws0 + w_i[9] + ws1;
    w_nxt = {wn, w_i[15:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r   <= st_nxt;
      w_r    <= w_nxt;
      base_r <= base_i;
      tag_r  <= tag_i;
    end
  end

  assign vld_o  = vld_r;
  assign st_o   = st_r;
  assign w_o    = w_r;
  assign base_o = base_r;
  assign tag_o  = tag_r;

endmodule

@@ hw/rtl/shapow_block.sv @@
// Full 64-round compression of one block, one round per stage, with final add.
module shapow_block (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 vld_i,
  input  shapow_pkg::hstate_t  h_i,
  input  shapow_pkg::sched_t   w_i,
  input  shapow_pkg::tag_t     tag_i,
  output logic                 vld_o,
  output shapow_pkg::hstate_t  h_o,
  output shapow_pkg::tag_t     tag_o
);

  logic                vld [shapow_pkg::NumRounds+1];
  shapow_pkg::hstate_t st  [shapow_pkg::NumRounds+1];
  shapow_pkg::hstate_t bs  [shapow_pkg::NumRounds+1];
  shapow_pkg::sched_t  ws  [shapow_pkg::NumRounds+1];
  shapow_pkg::tag_t    tg  [shapow_pkg::NumRounds+1];
  logic                vld_r;
  shapow_pkg::hstate_t h_r;
  shapow_pkg::tag_t    tag_r;

  assign vld[0] = vld_i;
  assign st[0]  = h_i;
  assign bs[0]  = h_i;
  assign ws[0]  = w_i;
  assign tg[0]  = tag_i;

  for (genvar g = 0; g < shapow_pkg::NumRounds; g++) begin : g_rnd
    shapow_round u_round (
      .clk, .rst_n, .adv,
      .rnd(6'(g)),
      .vld_i(vld[g]), .st_i(st[g]), .w_i(ws[g]), .base_i(bs[g]), .tag_i(tg[g]),
      .vld_o(vld[g+1]), .st_o(st[g+1]), .w_o(ws[g+1]), .base_o(bs[g+1]),
      .tag_o(tg[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld[shapow_pkg::NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= bs[shapow_pkg::NumRounds][i] + st[shapow_pkg::NumRounds][i];
      end
      tag_r <= tg[shapow_pkg::NumRounds];
    end
  end

  assign vld_o = vld_r;
  assign h_o   = h_r;
  assign tag_o = tag_r;

endmodule

@@ hw/rtl/sha256_nonce_difficulty_check_unit.sv @@
// SHA-256 proof-of-work nonce checker.
// Input channel: in_valid/in_ready carry one 64-bit trial nonce per transaction.
// The message is 48 fixed text bytes, the mining key (little-endian), then the
// nonce (little-endian); it is hashed as two 512-bit blocks, the second being
// the constant padding block. Output channel: out_valid/out_ready carry hit,
// the echoed nonce and key, and the first digest word.
// Configuration: cfg_valid/cfg_ready write cfg_mining_key; cfg_ready is always
// high, and the key is captured with each nonce at input acceptance.
// Pipeline: one input register, 64 round stages plus a final-add stage per
// block, and the output register, 132 registers in all.
// Throughput is one nonce per cycle while the output is not stalled, set by
// the fully unrolled round stages.
// When out_ready is low with a result waiting, the whole pipe holds (in_ready
// drops only if the output register is full), so no transaction is lost or
// repeated. Synchronous active-low reset clears all valid bits and zeroes
// the key.
`include "assert_macros.svh"

module sha256_nonce_difficulty_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_trial_nonce,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [63:0] out_nonce_echo,
  output logic [63:0] out_key_echo,
  output logic [31:0] out_digest_head,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_mining_key
);

  logic [63:0] key_r;
  logic        adv;
  logic        s0_vld_r;
  shapow_pkg::tag_t   s0_tag_r;
  shapow_pkg::sched_t blk1_w, blk2_w;
  logic               b1_vld, b2_vld;
  shapow_pkg::hstate_t b1_h, b2_h;
  shapow_pkg::tag_t   b1_tag, b2_tag;
  logic        out_valid_r;
  logic        hit_r;
  logic [63:0] nonce_r, keyo_r;
  logic [31:0] head_r;

  // The pipe advances whenever the output register is empty or being drained.
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      key_r <= cfg_mining_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_tag_r.nonce <= in_trial_nonce;
      s0_tag_r.key   <= key_r;
    end
  end

  // First block: text words, then key and nonce as little-endian bytes.
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      blk1_w[i] = shapow_pkg::TextW[i];
    end
    blk1_w[12] = shapow_pkg::bswap32(s0_tag_r.key[31:0]);
    blk1_w[13] = shapow_pkg::bswap32(s0_tag_r.key[63:32]);
    blk1_w[14] = shapow_pkg::bswap32(s0_tag_r.nonce[31:0]);
    blk1_w[15] = shapow_pkg::bswap32(s0_tag_r.nonce[63:32]);
  end

  // Padding block for a 512-bit message.
  always_comb begin
    blk2_w     = '0;
    blk2_w[0]  = 32'h80000000;
    blk2_w[15] = 32'd512;
  end

  shapow_block u_blk1 (
    .clk, .rst_n, .adv,
    .vld_i(s0_vld_r), .h_i(shapow_pkg::InitH), .w_i(blk1_w), .tag_i(s0_tag_r),
    .vld_o(b1_vld), .h_o(b1_h), .tag_o(b1_tag)
  );

  shapow_block u_blk2 (
    .clk, .rst_n, .adv,
    .vld_i(b1_vld), .h_i(b1_h), .w_i(blk2_w), .tag_i(b1_tag),
    .vld_o(b2_vld), .h_o(b2_h), .tag_o(b2_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r   <= (b2_h[0][31:16] == 16'd0);
      head_r  <= b2_h[0];
      nonce_r <= b2_tag.nonce;
      keyo_r  <= b2_tag.key;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_digest_head = head_r;
  assign out_nonce_echo  = nonce_r;
  assign out_key_echo    = keyo_r;

  `ASSERT_IMPLY(a_hit_matches, clk, rst_n, out_valid, out_hit == (out_digest_head[31:16] == 16'd0))
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_nonce_echo))
  `ASSERT_IMPLY(a_ready_when_free, clk, rst_n, !out_valid, in_ready)

endmodule

@@ dv/sha256_nonce_difficulty_check_unit_tb.sv @@
`timescale 1ns / 100ps

module sha256_nonce_difficulty_check_unit_tb;

  // One result transaction as the block reports it.
  typedef struct {
    logic        hit;
    logic [63:0] nonce;
    logic [63:0] key;
    logic [31:0] head;
  } pow_result_t;

  // One row of the directed table. When has_head is set, the digest head is
  // typed in; otherwise the row is checked against the hash predictor only.
  typedef struct {
    logic [63:0] nonce;
    logic        load_key;
    logic [63:0] key;
    logic        has_head;
    logic [31:0] head;
  } pow_row_t;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PipeLatency = 140;
  localparam int unsigned NumRandom   = 600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_trial_nonce;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic [63:0] out_nonce_echo;
  logic [63:0] out_key_echo;
  logic [31:0] out_digest_head;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_mining_key;

  sha256_nonce_difficulty_check_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_trial_nonce  (in_trial_nonce),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_nonce_echo  (out_nonce_echo),
    .out_key_echo    (out_key_echo),
    .out_digest_head (out_digest_head),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_mining_key  (cfg_mining_key)
  );

  // Free-running clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // The predictor's own copy of the key register, and the results still owed.
  logic [63:0]  model_key;
  pow_result_t  pending_results[$];
  pow_result_t  typed_heads[$];
  logic         typed_valid[$];
  int unsigned  error_count;
  int unsigned  cycle_count;

  // Idle percentages for each side; the hold-off flag forces a long stall.
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  logic         recv_hold;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // The 48 fixed text bytes as big-endian message words 0 to 11.
  localparam logic [31:0] PhraseW [12] = '{
    32'h456d6265, 32'h64646564, 32'h20537973, 32'h74656d73,
    32'h20617265, 32'h2066756e, 32'h20616e64, 32'h20646f20,
    32'h61776573, 32'h6f6d6520, 32'h7468696e, 32'h67732120};

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of blk into the chaining value hv.
  function automatic void sha_compress(inout logic [31:0] hv [8],
                                       input logic [31:0] blk [16]);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
    e = hv[4]; f = hv[5]; g = hv[6]; hh = hv[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
    hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += hh;
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // Hash the message built from the current key and this nonce, and return
  // the result the block owes for it.
  function automatic pow_result_t predict_pow(input logic [63:0] nonce);
    logic [31:0] blk [16];
    logic [31:0] hv [8];
    pow_result_t res;
    for (int i = 0; i < 12; i++) blk[i] = PhraseW[i];
    // Little-endian bytes become big-endian words, hence the byte swap.
    blk[12] = swap_bytes(model_key[31:0]);
    blk[13] = swap_bytes(model_key[63:32]);
    blk[14] = swap_bytes(nonce[31:0]);
    blk[15] = swap_bytes(nonce[63:32]);
    for (int i = 0; i < 8; i++) hv[i] = StartH[i];
    sha_compress(hv, blk);
    // The second block is the fixed padding block for a 512-bit message.
    for (int i = 0; i < 16; i++) blk[i] = 32'h0;
    blk[0]  = 32'h80000000;
    blk[15] = 32'd512;
    sha_compress(hv, blk);
    res.hit   = (hv[0][31:16] == 16'h0);
    res.nonce = nonce;
    res.key   = model_key;
    res.head  = hv[0];
    return res;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pow_result_t exp_res;
    pow_result_t typed;
    logic        has_typed;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, nonce %h", $realtime, out_nonce_echo);
        error_count++;
      end else begin
        exp_res   = pending_results.pop_front();
        typed     = typed_heads.pop_front();
        has_typed = typed_valid.pop_front();
        if (has_typed && typed.head !== exp_res.head) begin
          $display("%0t: predictor head %h disagrees with typed head %h",
                   $realtime, exp_res.head, typed.head);
          error_count++;
        end
        if (out_hit !== exp_res.hit) begin
          $display("%0t: hit expected %b actual %b", $realtime, exp_res.hit, out_hit);
          error_count++;
        end
        if (out_nonce_echo !== exp_res.nonce) begin
          $display("%0t: nonce_echo expected %h actual %h",
                   $realtime, exp_res.nonce, out_nonce_echo);
          error_count++;
        end
        if (out_key_echo !== exp_res.key) begin
          $display("%0t: key_echo expected %h actual %h",
                   $realtime, exp_res.key, out_key_echo);
          error_count++;
        end
        if (out_digest_head !== exp_res.head) begin
          $display("%0t: digest_head expected %h actual %h",
                   $realtime, exp_res.head, out_digest_head);
          error_count++;
        end
      end
    end
  end

  // Receiver: out_ready changes on the falling edge only. A hold-off stalls
  // it completely while the sender keeps pushing.
  always @(negedge clk) begin
    if (recv_hold)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Offer one nonce and wait for the transaction; the prediction is made at
  // acceptance, against the key in force at that moment. Valid is left high
  // so the next nonce can follow at once; callers drop it before any pause.
  task automatic send_nonce(input logic [63:0] nonce, input logic has_head,
                            input logic [31:0] head);
    pow_result_t typed;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_trial_nonce <= nonce;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_pow(nonce));
    typed.head = head;
    typed_heads.push_back(typed);
    typed_valid.push_back(has_head);
    @(negedge clk);
  endtask

  // Stop offering, let the pipe drain, then give it the latency slack before
  // a key write.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PipeLatency) @(negedge clk);
  endtask

  // Write the key register; only done while the pipe is empty.
  task automatic write_key(input logic [63:0] key);
    cfg_valid      <= 1'b1;
    cfg_mining_key <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_key = key;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  pow_row_t directed_rows [$];

  function automatic pow_row_t make_row(input logic [63:0] nonce, input logic load_key,
                                        input logic [63:0] key);
    pow_row_t r;
    r.nonce = nonce; r.load_key = load_key; r.key = key;
    r.has_head = 1'b0; r.head = '0;
    return r;
  endfunction

  initial begin
    logic [63:0] nonce;
    logic [63:0] key;
    pow_row_t    row;
    cycle_count    = 0;
    error_count    = 0;
    model_key      = 64'h0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_trial_nonce = 64'h0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_mining_key = 64'h0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Extremes of nonce and key, single ones at either end,
    // alternating bit patterns, and a key change between rows, which must only show on later transactions.
    directed_rows.push_back(make_row(64'h0, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'hffff_ffff_ffff_ffff, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'h1, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'h8000_0000_0000_0000, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'h5555_5555_5555_5555, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'h0, 1'b1, 64'hffff_ffff_ffff_ffff));
    directed_rows.push_back(make_row(64'hffff_ffff_ffff_ffff, 1'b0, 64'h0));
    directed_rows.push_back(make_row(64'h0123_4567_89ab_cdef, 1'b1, 64'h1));
    directed_rows.push_back(make_row(64'h0123_4567_89ab_cdef, 1'b1, 64'h8000_0000_0000_0000));
    directed_rows.push_back(make_row(64'hfedc_ba98_7654_3210, 1'b1, 64'h0));
    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.load_key) begin
        wait_drained();
        write_key(row.key);
      end
      send_nonce(row.nonce, row.has_head, row.head);
    end
    wait_drained();

    // Random part in phases of idling: none, sender idle, receiver stalling,
    // both. Each phase starts with a fresh key, extremes among them.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 88 : 38) : 0;
      recv_idle_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 88 : 38) : 0;
      wait_drained();
      case (phase)
        0: key = 64'hffff_ffff_ffff_ffff;
        1: key = 64'h0;
        default: key = {$urandom, $urandom};
      endcase
      write_key(key);
      // A long receiver hold-off in the first phase lets the pipe fill up.
      if (phase == 0) begin
        fork
          begin
            recv_hold = 1'b1;
            for (int c = 0; c < 400; c++) @(negedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < NumRandom / 4; i++) begin
        case ($urandom_range(3, 0))
          0: nonce = {$urandom, $urandom} & {2{$urandom_range(1, 0) ? 32'hffff : 32'hffffffff}};
          1: nonce = 64'h1 << $urandom_range(63, 0);
          default: nonce = {$urandom, $urandom};
        endcase
        send_nonce(nonce, 1'b0, 32'h0);
        // Midway through the sender-idle phase, the sender pauses until every result is back.
        if (i == NumRandom / 8 && phase == 1) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    recv_idle_pct = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PipeLatency) @(negedge clk);

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/shapow_pkg.sv
hw/rtl/shapow_round.sv
hw/rtl/shapow_block.sv
hw/rtl/sha256_nonce_difficulty_check_unit.sv
dv/sha256_nonce_difficulty_check_unit_tb.sv
